// File: rtl/tdpt_pkg.sv
// Package for the trial-division prime test unit.
// Holds shared constants and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package tdpt_pkg;

   // Default width of the candidate value
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // First odd divisor tried and the step between divisors
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP  = 2;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // capture candidate, reset divisor and its square
      logic step;       // advance divisor to the next odd value
      logic div_start;  // start a remainder computation
   } tdpt_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic sq_le_n;    // divisor squared <= candidate
      logic div_done;   // remainder computation finished (one-cycle pulse)
      logic rem_zero;   // remainder is zero, valid with div_done
   } tdpt_sts_type;

endpackage

// File: rtl/tdpt_rem.sv
// Iterative remainder unit: one restoring-division bit per cycle.
// Depends on nothing but its ports.
`timescale 1ns / 1ps

module tdpt_rem #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic                   rem_zero
);

   localparam int CntWidth = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH:0]   trial;

   // Shift next dividend bit into the partial remainder, subtract if it fits
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         shift_in = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in   = CntWidth'(cnt_ff + 1'b1);
         if (cnt_ff == CntWidth'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// File: rtl/tdpt_datapath.sv
// Datapath of the prime test: candidate, divisor, running square, remainder unit.
// Depends on tdpt_pkg and tdpt_rem.
`timescale 1ns / 1ps

module tdpt_datapath #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tdpt_pkg::tdpt_cmd_type cmd,
   input  logic [VALUE_WIDTH-1:0] candidate,
   output tdpt_pkg::tdpt_sts_type sts
);

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [VALUE_WIDTH:0]   sq_ff, sq_in;
   logic                   div_done;
   logic                   rem_zero;

   // Divisor and its square; (d+s)^2 = d^2 + 2*s*d + s^2, with 2*s = 4
   always_comb begin
      n_in  = n_ff;
      d_in  = d_ff;
      sq_in = sq_ff;
      if (cmd.load) begin
         n_in  = candidate;
         d_in  = VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
         sq_in = (VALUE_WIDTH+1)'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
      end else if (cmd.step) begin
         d_in  = VALUE_WIDTH'(d_ff + VALUE_WIDTH'(tdpt_pkg::DIVISOR_STEP));
         sq_in = (VALUE_WIDTH+1)'(sq_ff + ({1'b0, d_ff} << 2)
                 + (VALUE_WIDTH+1)'(tdpt_pkg::DIVISOR_STEP * tdpt_pkg::DIVISOR_STEP));
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      d_ff  <= d_in;
      sq_ff <= sq_in;
   end

   // Remainder of candidate by current divisor
   tdpt_rem #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .done     (div_done),
      .rem_zero (rem_zero)
   );

   // Status back to controller
   always_comb begin
      sts.sq_le_n  = (sq_ff <= {1'b0, n_ff});
      sts.div_done = div_done;
      sts.rem_zero = rem_zero;
   end

endmodule

// File: rtl/tdpt_ctrl.sv
// Controller of the prime test: sequences bound checks and remainder runs.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps

module tdpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tdpt_pkg::tdpt_sts_type sts,
   output tdpt_pkg::tdpt_cmd_type cmd,
   output logic                   rsp_valid,
   output logic                   rsp_is_prime
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_is_prime_ff;

   assign busy = (state_ff != ST_IDLE);

   // Commands decoded from state and status
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load      = start;
         ST_CHECK:  cmd.div_start = sts.sq_le_n;
         ST_DIVIDE: cmd.step      = sts.div_done && !sts.rem_zero;
         default:   cmd = '0;
      endcase
   end

   // State and registered result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_is_prime_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (sts.sq_le_n) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  // no divisor up to the root divides it
                  state_ff        <= ST_IDLE;
                  rsp_valid_ff    <= 1'b1;
                  rsp_is_prime_ff <= 1'b1;
               end
            end
            ST_DIVIDE: begin
               if (sts.div_done) begin
                  if (sts.rem_zero) begin
                     state_ff        <= ST_IDLE;
                     rsp_valid_ff    <= 1'b1;
                     rsp_is_prime_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_CHECK;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // A transfer in makes the unit busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make unit busy");

   // Results appear only when an item has just finished
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without a finished item");

   // Remainder completion only arrives while waiting for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder done outside divide state");

endmodule

// File: rtl/trial_division_prime_test_unit.sv
// Top level of the trial-division prime test unit.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_datapath (and tdpt_rem below it).
//
// One candidate per transfer: start is taken when busy is low, and one
// rsp_valid strobe later carries rsp_is_prime for exactly one cycle; the
// receiver cannot stall it. Odd divisors 3, 5, 7, ... are tried while their
// square does not exceed the candidate; 2 is never tried, and values below 9
// report 1. Each tried divisor costs one bound check in ST_CHECK and one run
// of the one-bit-per-cycle remainder unit over all VALUE_WIDTH dividend
// bits; up to about 32768 divisors are tried for 32-bit primes. A new start
// is taken in the cycle the previous result strobe is shown.
`timescale 1ns / 1ps

module trial_division_prime_test_unit #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                   rsp_valid,
   output logic                   rsp_is_prime
);

   tdpt_pkg::tdpt_cmd_type cmd;
   tdpt_pkg::tdpt_sts_type sts;

   // Sequencing
   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .sts          (sts),
      .cmd          (cmd),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime)
   );

   // Arithmetic
   tdpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .candidate (req_candidate),
      .sts       (sts)
   );

endmodule
